FILE: src/jlsp_pkg.sv
// Shared widths, types and constants of the jerk-limited speed planner.
`default_nettype none
package jlsp_pkg;

    localparam int POS_W    = 32;
    localparam int A_W      = 16;
    localparam int J_W      = 20;
    localparam int S_W      = 31;
    localparam int AA_SHIFT = 7;
    localparam int AD_SHIFT = 9;

    localparam int NUM_W  = 2 * A_W + AA_SHIFT;
    localparam int C_W    = NUM_W;
    localparam int D_W    = POS_W;
    localparam int AD_W   = D_W + A_W;
    localparam int T_W    = AD_W + AD_SHIFT;
    localparam int CC_W   = 2 * C_W;
    localparam int SUM_W  = ((CC_W > T_W) ? CC_W : T_W) + 1;
    localparam int RAD_W  = SUM_W + (SUM_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int SREM_W = ROOT_W + 2;
    localparam int MX_W   = (C_W > D_W) ? C_W : D_W;
    localparam int MY_W   = C_W;
    localparam int P_W    = MX_W + MY_W;
    localparam int CNT_MAX = (C_W > ROOT_W) ? C_W : ROOT_W;
    localparam int CNT_W  = $clog2(CNT_MAX);
    localparam int CFG_W  = 2;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [D_W-1:0]          dist_t;
    typedef logic [A_W-1:0]          accel_t;
    typedef logic [J_W-1:0]          jerk_t;
    typedef logic [S_W-1:0]          speed_t;
    typedef logic [NUM_W-1:0]        num_t;
    typedef logic [C_W-1:0]          c_t;
    typedef logic [CC_W-1:0]         cc_t;
    typedef logic [AD_W-1:0]         ad_t;
    typedef logic [RAD_W-1:0]        rad_t;
    typedef logic [ROOT_W-1:0]       root_t;
    typedef logic [SREM_W-1:0]       srem_t;
    typedef logic [MX_W-1:0]         mx_t;
    typedef logic [P_W-1:0]          mp_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [CFG_W-1:0]        cfg_idx_t;

    localparam cfg_idx_t REG_ACCEL = cfg_idx_t'(0);
    localparam cfg_idx_t REG_JERK  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_CEIL  = cfg_idx_t'(2);
    localparam cfg_idx_t REG_STEP  = cfg_idx_t'(3);

    localparam accel_t ACCEL_RESET = accel_t'(1000);
    localparam jerk_t  JERK_RESET  = jerk_t'(5000);
    localparam speed_t CEIL_RESET  = speed_t'(256000);
    localparam speed_t STEP_RESET  = speed_t'(256);
    localparam speed_t SPEED_MAX   = '1;

    localparam cnt_t MUL_A_LAST = cnt_t'(A_W - 1);
    localparam cnt_t DIV_LAST   = cnt_t'(NUM_W - 1);
    localparam cnt_t MUL_C_LAST = cnt_t'(C_W - 1);
    localparam cnt_t SQRT_LAST  = cnt_t'(ROOT_W - 1);

endpackage
`default_nettype wire

FILE: src/jlsp_pos_if.sv
// Input channel: target and travelled position item.
`default_nettype none
interface jlsp_pos_if;
    logic             valid;
    logic             ready;
    jlsp_pkg::pos_t   target_position;
    jlsp_pkg::pos_t   travelled_position;

    modport source (output valid, output target_position, output travelled_position,
                    input ready);
    modport sink   (input valid, input target_position, input travelled_position,
                    output ready);
endinterface
`default_nettype wire

FILE: src/jlsp_speed_if.sv
// Output channel: commanded speed item.
`default_nettype none
interface jlsp_speed_if;
    logic             valid;
    logic             ready;
    jlsp_pkg::speed_t commanded_speed;

    modport source (output valid, output commanded_speed, input ready);
    modport sink   (input valid, input commanded_speed, output ready);
endinterface
`default_nettype wire

FILE: src/jerk_limited_speed_planner_top.sv
// Jerk-limited speed planner: bit-serial multiply, divide and square root per item.
// One item at a time: a new item is accepted only in the idle state, after the
//   previous result has been loaded into the output register; the output register
//   holds a result while the next item is accepted and worked on, and a finished
//   result waits in ST_LIMIT while that register is still full.
// Reset: limits take their defaults, stored speed is 0, no result pending.
`default_nettype none
module jerk_limited_speed_planner_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire jlsp_pkg::cfg_idx_t  cfg_index,
    input  wire jlsp_pkg::speed_t    cfg_data,
    jlsp_pos_if.sink                 pos,
    jlsp_speed_if.source             speed
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_AA,
        ST_DIV,
        ST_MUL_CC,
        ST_MUL_AD,
        ST_RAD,
        ST_SQRT,
        ST_FSAT,
        ST_MIN,
        ST_LIMIT
    } state_t;

    state_t               state_reg;
    jlsp_pkg::cnt_t       cnt_reg;
    logic                 pass_reg;
    logic                 out_valid_reg;
    jlsp_pkg::accel_t     accel_reg;
    jlsp_pkg::jerk_t      jerk_reg;
    jlsp_pkg::speed_t     ceil_reg;
    jlsp_pkg::speed_t     step_reg;
    jlsp_pkg::speed_t     last_reg;

    jlsp_pkg::dist_t      ds_reg;
    jlsp_pkg::dist_t      de_reg;
    jlsp_pkg::mx_t        mx_reg;
    jlsp_pkg::mp_t        mp_reg;
    jlsp_pkg::num_t       dq_reg;
    jlsp_pkg::jerk_t      drem_reg;
    jlsp_pkg::c_t         c_reg;
    jlsp_pkg::cc_t        cc_reg;
    jlsp_pkg::rad_t       rad_reg;
    jlsp_pkg::srem_t      srem_reg;
    jlsp_pkg::root_t      root_reg;
    jlsp_pkg::speed_t     vs_reg;
    jlsp_pkg::speed_t     ve_reg;
    jlsp_pkg::speed_t     vmin_reg;
    jlsp_pkg::speed_t     out_speed_reg;

    logic                 accept;
    logic                 out_load;
    jlsp_pkg::jerk_t      j_eff;
    logic signed [jlsp_pkg::POS_W:0] rem_diff;
    jlsp_pkg::dist_t      ds_in;
    jlsp_pkg::dist_t      de_in;

    logic [jlsp_pkg::MX_W:0]     mul_sum;
    jlsp_pkg::mp_t               mul_p_next;
    logic [2*jlsp_pkg::A_W-1:0]  aa;
    jlsp_pkg::ad_t               ad;

    logic [jlsp_pkg::J_W:0]      div_trial;
    logic                        div_ge;
    jlsp_pkg::jerk_t             drem_next;
    jlsp_pkg::num_t              dq_next;

    logic [jlsp_pkg::SREM_W+1:0] s_sh;
    logic [jlsp_pkg::SREM_W+1:0] s_trial;
    logic [jlsp_pkg::SREM_W+1:0] s_diff;
    logic                        s_ge;
    jlsp_pkg::srem_t             srem_next;
    jlsp_pkg::root_t             root_next;

    jlsp_pkg::root_t             f_full;
    jlsp_pkg::speed_t            f_sat;
    jlsp_pkg::speed_t            vmin_next;
    logic [jlsp_pkg::S_W:0]      v_hi;
    jlsp_pkg::speed_t            v_up;
    jlsp_pkg::speed_t            v_lo;
    jlsp_pkg::speed_t            v_lim;

    assign accept   = pos.valid && (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_LIMIT) && (!out_valid_reg || speed.ready);

    assign pos.ready             = (state_reg == ST_IDLE);
    assign speed.valid           = out_valid_reg;
    assign speed.commanded_speed = out_speed_reg;

    assign j_eff = (jerk_reg == '0) ? jlsp_pkg::jerk_t'(1) : jerk_reg;

    // distances: travelled and remaining, clamped at zero
    assign rem_diff = {pos.target_position[jlsp_pkg::POS_W-1], pos.target_position}
                    - {pos.travelled_position[jlsp_pkg::POS_W-1], pos.travelled_position};
    assign ds_in = pos.travelled_position[jlsp_pkg::POS_W-1]
                 ? '0 : jlsp_pkg::dist_t'(pos.travelled_position);
    assign de_in = rem_diff[jlsp_pkg::POS_W] ? '0 : rem_diff[jlsp_pkg::POS_W-1:0];

    // shift-add multiplier, one multiplier bit per cycle, LSB first
    assign mul_sum    = {1'b0, mp_reg[jlsp_pkg::P_W-1 -: jlsp_pkg::MX_W]}
                      + (mp_reg[0] ? {1'b0, mx_reg} : '0);
    assign mul_p_next = {mul_sum, mp_reg[jlsp_pkg::MY_W-1:1]};
    assign aa = mul_p_next[jlsp_pkg::MY_W-jlsp_pkg::A_W +: 2*jlsp_pkg::A_W];
    assign ad = mp_reg[jlsp_pkg::MY_W-jlsp_pkg::A_W +: jlsp_pkg::AD_W];

    // restoring divider, one quotient bit per cycle
    assign div_trial = {drem_reg, dq_reg[jlsp_pkg::NUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, j_eff});
    assign drem_next = div_ge ? jlsp_pkg::jerk_t'(div_trial - {1'b0, j_eff})
                              : div_trial[jlsp_pkg::J_W-1:0];
    assign dq_next   = {dq_reg[jlsp_pkg::NUM_W-2:0], div_ge};

    // digit-by-digit square root, two radicand bits per cycle
    assign s_sh      = {srem_reg, rad_reg[jlsp_pkg::RAD_W-1 -: 2]};
    assign s_trial   = {2'b00, root_reg, 2'b01};
    assign s_ge      = (s_sh >= s_trial);
    assign s_diff    = s_sh - s_trial;
    assign srem_next = s_ge ? s_diff[jlsp_pkg::SREM_W-1:0] : s_sh[jlsp_pkg::SREM_W-1:0];
    assign root_next = {root_reg[jlsp_pkg::ROOT_W-2:0], s_ge};

    assign f_full = root_reg - jlsp_pkg::root_t'(c_reg);
    assign f_sat  = (|f_full[jlsp_pkg::ROOT_W-1:jlsp_pkg::S_W])
                  ? jlsp_pkg::SPEED_MAX : f_full[jlsp_pkg::S_W-1:0];

    always_comb
    begin
        vmin_next = ceil_reg;
        if (vs_reg < vmin_next)
        begin
            vmin_next = vs_reg;
        end
        if (ve_reg < vmin_next)
        begin
            vmin_next = ve_reg;
        end
    end

    assign v_hi  = {1'b0, last_reg} + {1'b0, step_reg};
    assign v_up  = ({1'b0, vmin_reg} > v_hi) ? v_hi[jlsp_pkg::S_W-1:0] : vmin_reg;
    assign v_lo  = last_reg - step_reg;
    assign v_lim = ((last_reg > step_reg) && (v_up < v_lo)) ? v_lo : v_up;

    // control: sequencer, limits, stored speed, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            accel_reg     <= jlsp_pkg::ACCEL_RESET;
            jerk_reg      <= jlsp_pkg::JERK_RESET;
            ceil_reg      <= jlsp_pkg::CEIL_RESET;
            step_reg      <= jlsp_pkg::STEP_RESET;
            last_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    jlsp_pkg::REG_ACCEL: accel_reg <= cfg_data[jlsp_pkg::A_W-1:0];
                    jlsp_pkg::REG_JERK:  jerk_reg  <= cfg_data[jlsp_pkg::J_W-1:0];
                    jlsp_pkg::REG_CEIL:  ceil_reg  <= cfg_data;
                    jlsp_pkg::REG_STEP:  step_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (speed.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_MUL_AA;
                        cnt_reg   <= '0;
                        pass_reg  <= 1'b0;
                    end
                end
                ST_MUL_AA:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == jlsp_pkg::MUL_A_LAST)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == jlsp_pkg::DIV_LAST)
                    begin
                        state_reg <= ST_MUL_CC;
                        cnt_reg   <= '0;
                    end
                end
                ST_MUL_CC:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == jlsp_pkg::MUL_C_LAST)
                    begin
                        state_reg <= ST_MUL_AD;
                        cnt_reg   <= '0;
                    end
                end
                ST_MUL_AD:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == jlsp_pkg::MUL_A_LAST)
                    begin
                        state_reg <= ST_RAD;
                        cnt_reg   <= '0;
                    end
                end
                ST_RAD:
                begin
                    state_reg <= ST_SQRT;
                    cnt_reg   <= '0;
                end
                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == jlsp_pkg::SQRT_LAST)
                    begin
                        state_reg <= ST_FSAT;
                        cnt_reg   <= '0;
                    end
                end
                ST_FSAT:
                begin
                    if (!pass_reg)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= ST_MUL_AD;
                    end
                    else
                    begin
                        state_reg <= ST_MIN;
                    end
                end
                ST_MIN:
                begin
                    state_reg <= ST_LIMIT;
                end
                ST_LIMIT:
                begin
                    if (out_load)
                    begin
                        last_reg  <= v_lim;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ds_reg <= ds_in;
                    de_reg <= de_in;
                    mx_reg <= jlsp_pkg::mx_t'(accel_reg);
                    mp_reg <= jlsp_pkg::mp_t'(accel_reg);
                end
            end
            ST_MUL_AA:
            begin
                mp_reg <= mul_p_next;
                if (cnt_reg == jlsp_pkg::MUL_A_LAST)
                begin
                    dq_reg   <= {aa, {jlsp_pkg::AA_SHIFT{1'b0}}};
                    drem_reg <= '0;
                end
            end
            ST_DIV:
            begin
                dq_reg   <= dq_next;
                drem_reg <= drem_next;
                if (cnt_reg == jlsp_pkg::DIV_LAST)
                begin
                    c_reg  <= dq_next;
                    mx_reg <= jlsp_pkg::mx_t'(dq_next);
                    mp_reg <= jlsp_pkg::mp_t'(dq_next);
                end
            end
            ST_MUL_CC:
            begin
                if (cnt_reg == jlsp_pkg::MUL_C_LAST)
                begin
                    cc_reg <= mul_p_next[jlsp_pkg::CC_W-1:0];
                    mx_reg <= jlsp_pkg::mx_t'(ds_reg);
                    mp_reg <= jlsp_pkg::mp_t'(accel_reg);
                end
                else
                begin
                    mp_reg <= mul_p_next;
                end
            end
            ST_MUL_AD:
            begin
                mp_reg <= mul_p_next;
            end
            ST_RAD:
            begin
                rad_reg  <= jlsp_pkg::rad_t'(cc_reg)
                          + jlsp_pkg::rad_t'({ad, {jlsp_pkg::AD_SHIFT{1'b0}}});
                srem_reg <= '0;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                rad_reg  <= {rad_reg[jlsp_pkg::RAD_W-3:0], 2'b00};
                srem_reg <= srem_next;
                root_reg <= root_next;
            end
            ST_FSAT:
            begin
                if (!pass_reg)
                begin
                    vs_reg <= f_sat;
                    mx_reg <= jlsp_pkg::mx_t'(de_reg);
                    mp_reg <= jlsp_pkg::mp_t'(accel_reg);
                end
                else
                begin
                    ve_reg <= f_sat;
                end
            end
            ST_MIN:
            begin
                vmin_reg <= vmin_next;
            end
            ST_LIMIT:
            begin
                if (out_load)
                begin
                    out_speed_reg <= v_lim;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for the jerk-limited speed planner: directed and random ticks checked by a predictor.
module testbench;
    import jlsp_pkg::*;

    localparam int HOLD_CYCLES = 1000;
    localparam int MAX_LINES   = 200;
    localparam pos_t POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam pos_t POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

    typedef struct packed {
        pos_t target;
        pos_t travelled;
    } pos_pair_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    speed_t   cfg_data;

    jlsp_pos_if   pos_ch ();
    jlsp_speed_if speed_ch ();

    jerk_limited_speed_planner_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos       (pos_ch),
        .speed     (speed_ch)
    );

    pos_pair_t pos_pend_q[$];
    speed_t    speed_expect_q[$];

    accel_t lim_accel;
    jerk_t  lim_jerk;
    speed_t lim_ceil;
    speed_t lim_step;
    speed_t held_speed;

    bit idle_on;
    bit hold_go;
    int hold_left;
    int tx_wait;
    int rx_wait;
    int n_errors;

    always #5 clk = ~clk;

    function automatic logic [63:0] isqrt128(input logic [127:0] rad);
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [127:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            sq = {64'd0, trial} * {64'd0, trial};
            if (sq <= rad)
                root = trial;
        end
        return root;
    endfunction

    // allowed speed after or before a distance, 8 fraction bits
    function automatic logic [63:0] reach_speed(input logic signed [63:0] span);
        logic [63:0]  jj;
        logic [63:0]  cc;
        logic [63:0]  v;
        logic [127:0] rad;
        if (span <= 0)
            return 64'd0;
        jj = (lim_jerk == '0) ? 64'd1 : 64'(lim_jerk);
        cc = (64'(lim_accel) * 64'(lim_accel) * 64'd128) / jj;
        rad = 128'(cc) * 128'(cc) + 128'(64'(lim_accel) * 64'd512) * 128'($unsigned(span));
        v = isqrt128(rad) - cc;
        return (v > 64'(SPEED_MAX)) ? 64'(SPEED_MAX) : v;
    endfunction

    function automatic speed_t plan_speed(input pos_t target, input pos_t travelled);
        logic signed [63:0] goal;
        logic signed [63:0] odo;
        logic signed [63:0] left;
        logic [63:0]        vs;
        logic [63:0]        ve;
        logic [63:0]        v;
        logic [63:0]        last;
        logic [63:0]        step;
        goal = 64'(target);
        odo = 64'(travelled);
        left = goal - odo;
        if (left < 0)
            left = 0;
        vs = reach_speed(odo);
        ve = reach_speed(left);
        v = 64'(lim_ceil);
        if (vs < v)
            v = vs;
        if (ve < v)
            v = ve;
        last = 64'(held_speed);
        step = 64'(lim_step);
        if (v > last + step)
            v = last + step;
        if (last > step && v < last - step)
            v = last - step;
        held_speed = speed_t'(v);
        return held_speed;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_LINES)
            $display("mismatch at %0t: %s", $time, msg);
        n_errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        pos_pair_t item;
        if (!rst_n)
        begin
            pos_ch.valid <= 1'b0;
            tx_wait <= 0;
        end
        else
        begin
            if (pos_ch.valid && pos_ch.ready)
                speed_expect_q.push_back(plan_speed(pos_ch.target_position,
                                                    pos_ch.travelled_position));
            if (!pos_ch.valid || pos_ch.ready)
            begin
                if (tx_wait != 0)
                begin
                    tx_wait <= tx_wait - 1;
                    pos_ch.valid <= 1'b0;
                end
                else if (pos_pend_q.size() != 0)
                begin
                    item = pos_pend_q.pop_front();
                    pos_ch.target_position <= item.target;
                    pos_ch.travelled_position <= item.travelled;
                    pos_ch.valid <= 1'b1;
                    tx_wait <= idle_on ? $urandom_range(0, 4) : 0;
                end
                else
                    pos_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        int     n_wait;
        speed_t want;
        if (!rst_n)
        begin
            speed_ch.ready <= 1'b0;
            rx_wait <= 0;
        end
        else
        begin
            n_wait = rx_wait;
            if (speed_ch.valid && speed_ch.ready)
            begin
                if (speed_expect_q.size() == 0)
                    report_mismatch($sformatf("unexpected speed %0d",
                                              speed_ch.commanded_speed));
                else
                begin
                    want = speed_expect_q.pop_front();
                    if (speed_ch.commanded_speed !== want)
                        report_mismatch($sformatf("commanded_speed %0d, expected %0d",
                                                  speed_ch.commanded_speed, want));
                end
                n_wait = idle_on ? $urandom_range(0, 4) : 0;
            end
            else if (rx_wait != 0)
                n_wait = rx_wait - 1;
            rx_wait <= n_wait;
            speed_ch.ready <= (n_wait == 0) && (hold_left == 0);
        end
    end

    task automatic write_limit(input cfg_idx_t idx, input speed_t data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_ACCEL: lim_accel = accel_t'(data);
            REG_JERK:  lim_jerk = jerk_t'(data);
            REG_CEIL:  lim_ceil = data;
            REG_STEP:  lim_step = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(input speed_t a, input speed_t j, input speed_t c,
                              input speed_t s);
        write_limit(REG_ACCEL, a);
        write_limit(REG_JERK, j);
        write_limit(REG_CEIL, c);
        write_limit(REG_STEP, s);
    endtask

    task automatic queue_pair(input pos_t target, input pos_t travelled);
        pos_pair_t item;
        item.target = target;
        item.travelled = travelled;
        pos_pend_q.push_back(item);
    endtask

    // mostly approach runs toward a goal, some noise and odometer jumps
    task automatic queue_random(input int count);
        logic signed [63:0] goal;
        logic signed [63:0] odo;
        logic signed [63:0] stride;
        int made;
        int len;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                queue_pair(pos_t'($urandom), pos_t'($urandom));
                made++;
            end
            else
            begin
                goal = 64'($urandom) >> $urandom_range(1, 31);
                if ($urandom_range(0, 7) == 0)
                    goal = -goal;
                len = $urandom_range(6, 30);
                stride = ((goal < 0) ? -goal : goal) / len + 1;
                odo = -stride * $urandom_range(0, 2);
                for (int i = 0; i < len + 4 && made < count; i++)
                begin
                    queue_pair(pos_t'(goal), pos_t'(odo));
                    made++;
                    odo = odo + stride + $urandom_range(0, 7);
                    if ($urandom_range(0, 15) == 0)
                        odo = odo - 3 * stride;
                end
            end
        end
    endtask

    task automatic drain();
        while (pos_pend_q.size() != 0 || pos_ch.valid || speed_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ACCEL;
        cfg_data = '0;
        pos_ch.valid = 1'b0;
        pos_ch.target_position = '0;
        pos_ch.travelled_position = '0;
        speed_ch.ready = 1'b0;
        hold_go = 1'b0;
        idle_on = 1'b1;
        n_errors = 0;
        lim_accel = ACCEL_RESET;
        lim_jerk = JERK_RESET;
        lim_ceil = CEIL_RESET;
        lim_step = STEP_RESET;
        held_speed = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: field extremes, negative odometer, past target
        queue_pair('0, '0);
        queue_pair(POS_MAX, '0);
        queue_pair(POS_MAX, POS_MAX);
        queue_pair(POS_MIN, POS_MIN);
        queue_pair('0, POS_MIN);
        queue_pair(POS_MAX, POS_MIN);
        queue_pair(POS_MIN, POS_MAX);
        queue_pair(pos_t'(256000), pos_t'(-256));
        queue_pair(pos_t'(1000), pos_t'(2000));
        queue_pair(pos_t'(512000), pos_t'(256));
        queue_pair(pos_t'(512000), pos_t'(25600));
        queue_pair(pos_t'(512000), pos_t'(511900));
        queue_random(100);
        drain();

        // widest limits
        idle_on = 1'b0;
        set_limits(speed_t'(16'hFFFF), speed_t'(20'hFFFFF), SPEED_MAX, SPEED_MAX);
        queue_pair(POS_MAX, '0);
        queue_pair(POS_MAX, POS_MIN);
        queue_pair(POS_MAX, pos_t'(1));
        queue_pair(pos_t'(1), '0);
        queue_pair(POS_MIN, pos_t'(-1));
        queue_pair(POS_MAX, POS_MAX);
        queue_pair(POS_MAX, pos_t'(POS_MAX - 1));
        queue_pair(pos_t'(1 << 20), pos_t'(1 << 10));
        queue_random(80);
        drain();

        // zero ceiling and zero step
        idle_on = 1'b1;
        set_limits(speed_t'(1), speed_t'(1), '0, '0);
        queue_random(40);
        drain();

        // zero acceleration by dropped upper bits, zero jerk
        set_limits(speed_t'(31'h7FFF_0000), speed_t'(31'h7FF0_0000), SPEED_MAX,
                   speed_t'(5000));
        queue_random(40);
        drain();

        // receiver holds off while items keep coming
        idle_on = 1'b0;
        set_limits(speed_t'(3000), speed_t'(20000), speed_t'(1000000), speed_t'(2000));
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        queue_random(60);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            idle_on = $urandom_range(0, 1);
            set_limits(speed_t'($urandom_range(1, 65535)),
                       speed_t'($urandom_range(1, 1048575)),
                       speed_t'($urandom),
                       speed_t'($urandom >> $urandom_range(0, 31)));
            queue_random(80);
            drain();
        end

        repeat (250) @(posedge clk);
        if (n_errors == 0 && speed_expect_q.size() == 0)
            $display("PASS jerk_limited_speed_planner_top");
        else
            $display("FAIL jerk_limited_speed_planner_top");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("FAIL jerk_limited_speed_planner_top");
        $finish;
    end

endmodule
